### src/cse_pkg.sv
// Package for the sorting engine: shared types, codes and widths.
// Used by cse_ctrl, cse_datapath and counting_sort_engine_top; no dependencies.
`default_nettype none
package cse_pkg;
    localparam int DATA_W = 32;
    localparam int CNT_W  = 11;

    typedef enum logic [1:0] {
        ALG_SELECTION = 2'd0,
        ALG_BUBBLE    = 2'd1,
        ALG_INSERTION = 2'd2,
        ALG_RESERVED  = 2'd3
    } alg_t;

    typedef enum logic [3:0] {
        OP_NONE   = 4'd0,
        OP_LOAD   = 4'd1,
        OP_RDA    = 4'd2,
        OP_RDB    = 4'd3,
        OP_WRA    = 4'd4,
        OP_WRB    = 4'd5,
        OP_CLEAR  = 4'd6,
        OP_EMIT   = 4'd7,
        OP_WRD    = 4'd8
    } op_t;

    typedef struct packed {
        op_t  op;
        logic a_to_ra;
        logic b_to_rb;
        logic cmp_inc;
        logic swp_inc;
        logic wr_from_b;
        logic last;
    } cmd_t;

    typedef struct packed {
        logic b_lt_a;
        logic a_lt_b;
    } stat_t;
endpackage
`default_nettype wire

### src/cse_datapath.sv
// Datapath of the sorting engine: element memory, two operand registers, counters.
// Depends on cse_pkg; driven by cse_ctrl through cmd_t.
`default_nettype none
module cse_datapath #(
    parameter int AW = 6
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire cse_pkg::cmd_t             cmd,
    input  wire logic [AW-1:0]             addr,
    input  wire logic [cse_pkg::DATA_W-1:0] wdata,
    output cse_pkg::stat_t                 stat,
    output logic [cse_pkg::DATA_W-1:0]     rb,
    output logic [cse_pkg::CNT_W-1:0]      cmp_cnt,
    output logic [cse_pkg::CNT_W-1:0]      swp_cnt
);
    logic [cse_pkg::DATA_W-1:0] mem [0:(1<<AW)-1];
    logic [cse_pkg::DATA_W-1:0] rd_reg;
    logic [cse_pkg::DATA_W-1:0] ra_reg, rb_reg;
    logic [cse_pkg::CNT_W-1:0]  cmp_reg, swp_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.op == cse_pkg::OP_LOAD)
        begin
            mem[addr] <= wdata;
        end
        else if (cmd.op == cse_pkg::OP_WRA)
        begin
            mem[addr] <= ra_reg;
        end
        else if (cmd.op == cse_pkg::OP_WRB)
        begin
            mem[addr] <= rb_reg;
        end
        else if (cmd.op == cse_pkg::OP_WRD)
        begin
            mem[addr] <= rd_reg;
        end
        rd_reg <= mem[addr];
        if (cmd.a_to_ra)
        begin
            ra_reg <= rd_reg;
        end
        if (cmd.b_to_rb)
        begin
            rb_reg <= rd_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_reg <= '0;
            swp_reg <= '0;
        end
        else if (cmd.op == cse_pkg::OP_CLEAR)
        begin
            cmp_reg <= '0;
            swp_reg <= '0;
        end
        else
        begin
            if (cmd.cmp_inc)
            begin
                cmp_reg <= cmp_reg + 1'b1;
            end
            if (cmd.swp_inc)
            begin
                swp_reg <= swp_reg + 1'b1;
            end
        end
    end

    assign stat.b_lt_a = $signed(rb_reg) < $signed(ra_reg);
    assign stat.a_lt_b = $signed(ra_reg) < $signed(rb_reg);
    assign rb = rb_reg;
    assign cmp_cnt = cmp_reg;
    assign swp_cnt = swp_reg;
endmodule
`default_nettype wire

### src/cse_ctrl.sv
// Controller of the sorting engine: load counting, sort sequencing, emit burst.
// Depends on cse_pkg; commands cse_datapath through cmd_t and an address.
`default_nettype none
module cse_ctrl #(
    parameter int MAX_ELEMENTS = 64,
    parameter int AW = 6
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              is_final,
    input  wire cse_pkg::alg_t     alg,
    input  wire cse_pkg::stat_t    stat,
    output logic                   busy,
    output cse_pkg::cmd_t          cmd,
    output logic [AW-1:0]          addr,
    output logic                   emit_valid,
    output logic                   emit_last
);
    localparam int CW = AW + 1;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_OUTER = 12'b000000000010,
        S_RDA   = 12'b000000000100,
        S_RDAW  = 12'b000000001000,
        S_RDB   = 12'b000000010000,
        S_RDBW  = 12'b000000100000,
        S_CMP   = 12'b000001000000,
        S_WR1   = 12'b000010000000,
        S_WR2   = 12'b000100000000,
        S_ERD   = 12'b001000000000,
        S_EWT   = 12'b010000000000,
        S_EOUT  = 12'b100000000000
    } state_t;

    state_t         state_reg, state_next;
    logic [CW-1:0]  n_reg, n_next;
    logic [CW-1:0]  i_reg, i_next;
    logic [CW-1:0]  j_reg, j_next;
    logic [CW-1:0]  m_reg, m_next;
    logic           moved_reg, moved_next;
    logic [CW-1:0]  ad;
    logic           sel, bub;

    assign sel = (alg == cse_pkg::ALG_SELECTION);
    assign bub = (alg == cse_pkg::ALG_BUBBLE);

    // Selection: ra = store[m], rb = store[j]. Bubble: ra = store[j], rb = store[j+1].
    // Insertion: ra = key, rb = store[j-1], j is the hole position.
    always_comb
    begin
        state_next = state_reg;
        n_next = n_reg;
        i_next = i_reg;
        j_next = j_reg;
        m_next = m_reg;
        moved_next = moved_reg;
        cmd = '0;
        ad = '0;
        emit_valid = 1'b0;
        emit_last = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                ad = n_reg;
                if (start)
                begin
                    if (n_reg < CW'(MAX_ELEMENTS))
                    begin
                        cmd.op = cse_pkg::OP_LOAD;
                        n_next = n_reg + 1'b1;
                    end
                    if (is_final)
                    begin
                        cmd.op = (n_reg < CW'(MAX_ELEMENTS)) ? cse_pkg::OP_LOAD
                                                              : cse_pkg::OP_NONE;
                        state_next = S_OUTER;
                        i_next = sel || bub ? '0 : CW'(1);
                        moved_next = 1'b0;
                    end
                end
            end
            S_OUTER:
            begin
                if (i_reg == '0 && (sel || bub) && n_next == n_reg)
                begin
                    cmd.op = cse_pkg::OP_CLEAR;
                end
                if (sel || bub)
                begin
                    if (i_reg + 1'b1 >= n_reg || (bub && i_reg != '0 && !moved_reg))
                    begin
                        state_next = S_ERD;
                        j_next = '0;
                    end
                    else
                    begin
                        m_next = i_reg;
                        j_next = sel ? i_reg + 1'b1 : '0;
                        moved_next = 1'b0;
                        state_next = S_RDA;
                    end
                end
                else
                begin
                    if (i_reg == CW'(1))
                    begin
                        cmd.op = cse_pkg::OP_CLEAR;
                    end
                    if (i_reg >= n_reg)
                    begin
                        state_next = S_ERD;
                        j_next = '0;
                    end
                    else
                    begin
                        j_next = i_reg;
                        state_next = S_RDA;
                    end
                end
            end
            S_RDA:
            begin
                ad = sel ? m_reg : (bub ? j_reg : i_reg);
                state_next = S_RDAW;
            end
            S_RDAW:
            begin
                cmd.a_to_ra = 1'b1;
                ad = sel ? j_reg : (bub ? j_reg + 1'b1 : j_reg - 1'b1);
                state_next = S_RDB;
            end
            S_RDB:
            begin
                ad = sel ? j_reg : (bub ? j_reg + 1'b1 : j_reg - 1'b1);
                state_next = S_RDBW;
            end
            S_RDBW:
            begin
                cmd.b_to_rb = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                cmd.cmp_inc = 1'b1;
                if (sel)
                begin
                    if (stat.b_lt_a)
                    begin
                        m_next = j_reg;
                    end
                    if (j_reg + 1'b1 < n_reg)
                    begin
                        j_next = j_reg + 1'b1;
                        state_next = S_RDA;
                    end
                    else if (stat.b_lt_a || m_reg != i_reg)
                    begin
                        state_next = S_WR1;
                    end
                    else
                    begin
                        i_next = i_reg + 1'b1;
                        state_next = S_OUTER;
                    end
                end
                else if (bub)
                begin
                    if (stat.b_lt_a)
                    begin
                        state_next = S_WR1;
                    end
                    else if (j_reg + CW'(2) < n_reg - i_reg)
                    begin
                        j_next = j_reg + 1'b1;
                        state_next = S_RDA;
                    end
                    else
                    begin
                        i_next = i_reg + 1'b1;
                        state_next = S_OUTER;
                    end
                end
                else
                begin
                    // Key smaller than store[j-1]: shift; otherwise place the key.
                    if (stat.a_lt_b)
                    begin
                        state_next = S_WR2;
                    end
                    else
                    begin
                        state_next = S_WR1;
                    end
                end
            end
            S_WR1:
            begin
                if (sel)
                begin
                    // The minimum goes to store[i] while the old store[i] is read back.
                    cmd.op = (m_reg == j_reg) ? cse_pkg::OP_WRB : cse_pkg::OP_WRA;
                    ad = i_reg;
                    state_next = S_WR2;
                end
                else if (bub)
                begin
                    cmd.op = cse_pkg::OP_WRB;
                    ad = j_reg;
                    state_next = S_WR2;
                end
                else
                begin
                    cmd.op = cse_pkg::OP_WRA;
                    ad = j_reg;
                    i_next = i_reg + 1'b1;
                    state_next = S_OUTER;
                end
            end
            S_WR2:
            begin
                if (sel)
                begin
                    cmd.op = cse_pkg::OP_WRD;
                    ad = m_reg;
                    cmd.swp_inc = 1'b1;
                    i_next = i_reg + 1'b1;
                    state_next = S_OUTER;
                end
                else if (bub)
                begin
                    cmd.op = cse_pkg::OP_WRA;
                    ad = j_reg + 1'b1;
                    cmd.swp_inc = 1'b1;
                    moved_next = 1'b1;
                    if (j_reg + CW'(2) < n_reg - i_reg)
                    begin
                        j_next = j_reg + 1'b1;
                        state_next = S_RDA;
                    end
                    else
                    begin
                        i_next = i_reg + 1'b1;
                        state_next = S_OUTER;
                    end
                end
                else
                begin
                    cmd.op = cse_pkg::OP_WRB;
                    ad = j_reg;
                    cmd.swp_inc = 1'b1;
                    j_next = j_reg - 1'b1;
                    if (j_reg == CW'(1))
                    begin
                        state_next = S_WR1;
                        j_next = '0;
                    end
                    else
                    begin
                        state_next = S_RDB;
                        j_next = j_reg - 1'b1;
                    end
                end
            end
            S_ERD:
            begin
                ad = j_reg;
                state_next = S_EWT;
            end
            S_EWT:
            begin
                ad = j_reg;
                state_next = S_EOUT;
                cmd.b_to_rb = 1'b1;
            end
            S_EOUT:
            begin
                emit_valid = 1'b1;
                emit_last = (j_reg + 1'b1 == n_reg);
                if (emit_last)
                begin
                    n_next = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                    state_next = S_ERD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign addr = ad[AW-1:0];
    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            n_reg <= '0;
            i_reg <= '0;
            j_reg <= '0;
            m_reg <= '0;
            moved_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg <= n_next;
            i_reg <= i_next;
            j_reg <= j_next;
            m_reg <= m_next;
            moved_reg <= moved_next;
        end
    end

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state not one-hot");
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= CW'(MAX_ELEMENTS)) else $error("element count overflow");
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        emit_last |=> state_reg == S_IDLE) else $error("burst did not end");
endmodule
`default_nettype wire

### src/counting_sort_engine_top.sv
// Top level of the sorting engine: APB register, controller and datapath.
// Depends on cse_pkg, cse_ctrl and cse_datapath.
// Loading takes one element per cycle while idle. The sort runs from the element memory
// with its single registered read port; a compare runs S_RDA to S_RDBW and S_CMP,
// a swap adds S_WR1 and S_WR2 (an insertion shift S_WR2, then S_RDB), a pass S_OUTER.
// The burst emits the sorted elements in order; reset clears counts and mode.
`default_nettype none
module counting_sort_engine_top #(
    parameter int MAX_ELEMENTS = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        start,
    output logic             busy,
    input  wire logic signed [31:0] value,
    input  wire logic        is_final,
    output logic             result_valid,
    output logic signed [31:0] sorted_value,
    output logic [10:0]      compares,
    output logic [10:0]      swaps,
    output logic             end_of_list
);
    localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

    cse_pkg::alg_t  alg_reg;
    cse_pkg::cmd_t  cmd;
    cse_pkg::stat_t stat;
    logic [AW-1:0]  addr;
    logic [31:0]    rb;
    logic           ev, el;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alg_reg <= cse_pkg::ALG_SELECTION;
        end
        else if (psel && penable && pwrite && paddr == 2'd0)
        begin
            alg_reg <= cse_pkg::alg_t'(pwdata[1:0]);
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {30'd0, alg_reg} : 32'd0;

    cse_ctrl #(.MAX_ELEMENTS(MAX_ELEMENTS), .AW(AW)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .is_final(is_final),
        .alg(alg_reg), .stat(stat), .busy(busy), .cmd(cmd), .addr(addr),
        .emit_valid(ev), .emit_last(el)
    );

    cse_datapath #(.AW(AW)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .addr(addr), .wdata(value),
        .stat(stat), .rb(rb), .cmp_cnt(compares), .swp_cnt(swaps)
    );

    assign result_valid = ev;
    assign sorted_value = rb;
    assign end_of_list = el;
endmodule
`default_nettype wire

### tb/testbench.sv
// Testbench for counting_sort_engine_top: loads lists, sorts them under every
// algorithm setting and checks each emitted beat against an in-bench predictor.
// Depends on cse_pkg and the engine RTL.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH = 64;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int RANDOM_ITEMS = 350;
    localparam int SETTLE_CYCLES = 60;

    typedef struct {
        logic signed [31:0] val;
        logic [10:0] cmp;
        logic [10:0] swp;
        logic eol;
    } sorted_beat_t;

    typedef struct {
        cse_pkg::alg_t alg;
        logic signed [31:0] val;
        logic fin;
        bit known;
    } load_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic start = 1'b0;
    logic busy;
    logic signed [31:0] value = '0;
    logic is_final = 1'b0;
    logic result_valid;
    logic signed [31:0] sorted_value;
    logic [10:0] compares;
    logic [10:0] swaps;
    logic end_of_list;

    counting_sort_engine_top dut (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    sorted_beat_t pending_beats[$];
    logic signed [31:0] list_buf[STORE_DEPTH];
    int list_len = 0;
    cse_pkg::alg_t cur_alg = cse_pkg::ALG_SELECTION;
    int mismatches = 0;
    int cycles = 0;
    int items_sent = 0;

    load_row_t load_table[] = '{
        '{cse_pkg::ALG_SELECTION, 32'sh8000_0000, 1'b1, 1'b1},
        '{cse_pkg::ALG_SELECTION, 32'sh7FFF_FFFF, 1'b1, 1'b1},
        '{cse_pkg::ALG_SELECTION, 32'sd0, 1'b1, 1'b1},
        '{cse_pkg::ALG_SELECTION, -32'sd1, 1'b1, 1'b1},
        '{cse_pkg::ALG_SELECTION, 32'sd5, 1'b0, 1'b0},
        '{cse_pkg::ALG_SELECTION, -32'sd3, 1'b0, 1'b0},
        '{cse_pkg::ALG_SELECTION, 32'sd5, 1'b1, 1'b0},
        '{cse_pkg::ALG_BUBBLE, 32'sd3, 1'b0, 1'b0},
        '{cse_pkg::ALG_BUBBLE, 32'sd2, 1'b0, 1'b0},
        '{cse_pkg::ALG_BUBBLE, 32'sd1, 1'b1, 1'b0},
        '{cse_pkg::ALG_BUBBLE, 32'sd1, 1'b0, 1'b0},
        '{cse_pkg::ALG_BUBBLE, 32'sd2, 1'b0, 1'b0},
        '{cse_pkg::ALG_BUBBLE, 32'sd3, 1'b1, 1'b0},
        '{cse_pkg::ALG_INSERTION, 32'sh7FFF_FFFF, 1'b0, 1'b0},
        '{cse_pkg::ALG_INSERTION, 32'sd0, 1'b0, 1'b0},
        '{cse_pkg::ALG_INSERTION, 32'sh8000_0000, 1'b1, 1'b0},
        '{cse_pkg::ALG_RESERVED, 32'sd7, 1'b0, 1'b0},
        '{cse_pkg::ALG_RESERVED, -32'sd7, 1'b1, 1'b0},
        '{cse_pkg::ALG_INSERTION, 32'sd1, 1'b0, 1'b0},
        '{cse_pkg::ALG_INSERTION, 32'sd1, 1'b0, 1'b0},
        '{cse_pkg::ALG_INSERTION, 32'sd1, 1'b1, 1'b0}
    };

    // Sorts the loaded list the way the engine does and, if queue_beats, queues one beat per element.
    task automatic sort_list(bit queue_beats);
        logic signed [31:0] a[STORE_DEPTH];
        logic signed [31:0] t;
        logic [10:0] ncmp;
        logic [10:0] nswp;
        int n;
        int m;
        int pos;
        bit moved;
        n = list_len;
        ncmp = '0;
        nswp = '0;
        for (int k = 0; k < n; k++)
            a[k] = list_buf[k];
        if (cur_alg == cse_pkg::ALG_SELECTION)
        begin
            for (int i = 0; i + 1 < n; i++)
            begin
                m = i;
                for (int j = i + 1; j < n; j++)
                begin
                    ncmp++;
                    if (a[j] < a[m])
                        m = j;
                end
                if (m != i)
                begin
                    t = a[i];
                    a[i] = a[m];
                    a[m] = t;
                    nswp++;
                end
            end
        end
        else if (cur_alg == cse_pkg::ALG_BUBBLE)
        begin
            for (int i = 0; i + 1 < n; i++)
            begin
                moved = 1'b0;
                for (int j = 0; j + 1 < n - i; j++)
                begin
                    ncmp++;
                    if (a[j] > a[j + 1])
                    begin
                        t = a[j];
                        a[j] = a[j + 1];
                        a[j + 1] = t;
                        nswp++;
                        moved = 1'b1;
                    end
                end
                if (!moved)
                    break;
            end
        end
        else
        begin
            for (int i = 1; i < n; i++)
            begin
                t = a[i];
                pos = i;
                while (pos > 0 && a[pos - 1] > t)
                begin
                    ncmp++;
                    a[pos] = a[pos - 1];
                    pos--;
                    nswp++;
                end
                if (pos > 0)
                    ncmp++;
                a[pos] = t;
            end
        end
        if (queue_beats)
            for (int k = 0; k < n; k++)
                pending_beats.push_back('{a[k], ncmp, nswp, k + 1 == n});
        list_len = 0;
    endtask

    task automatic write_algorithm(cse_pkg::alg_t alg);
        start <= 1'b0;
        @(posedge clk);
        while (pending_beats.size() != 0 || busy)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 2'd0;
        pwdata <= {30'($urandom_range(0, 32'h3FFF_FFFF)), alg};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cur_alg = alg;
    endtask

    task automatic send_item(logic signed [31:0] v, logic fin, int gap, bit known);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        value <= v;
        is_final <= fin;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
        if (list_len < STORE_DEPTH)
        begin
            list_buf[list_len] = v;
            list_len++;
        end
        if (fin)
        begin
            if (known)
                pending_beats.push_back('{v, 11'd0, 11'd0, 1'b1});
            sort_list(!known);
        end
    endtask

    function automatic int draw_gap(bit no_idle);
        if (no_idle)
            return 0;
        return $urandom_range(0, 14);
    endfunction

    function automatic logic signed [31:0] draw_value();
        case ($urandom_range(0, 5))
            0: return $signed($urandom_range(0, 8)) - 4;
            1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return $urandom();
        endcase
    endfunction

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        sorted_beat_t exp_beat;
        if (rst_n && result_valid)
        begin
            if (pending_beats.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: value %0d compares %0d swaps %0d last %0b",
                             sorted_value, compares, swaps, end_of_list);
            end
            else
            begin
                exp_beat = pending_beats.pop_front();
                if (sorted_value !== exp_beat.val || compares !== exp_beat.cmp ||
                    swaps !== exp_beat.swp || end_of_list !== exp_beat.eol)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                                 exp_beat.val, exp_beat.cmp, exp_beat.swp, exp_beat.eol,
                                 sorted_value, compares, swaps, end_of_list);
                end
            end
        end
    end

    initial
    begin
        int len;
        bit no_idle;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (load_table[r])
        begin
            if (list_len == 0 && load_table[r].alg != cur_alg)
                write_algorithm(load_table[r].alg);
            send_item(load_table[r].val, load_table[r].fin, draw_gap(r < 4),
                      load_table[r].known);
        end

        while (items_sent < RANDOM_ITEMS + load_table.size())
        begin
            if ($urandom_range(0, 3) == 0)
                write_algorithm(cse_pkg::alg_t'($urandom_range(0, 3)));
            if ($urandom_range(0, 11) == 0)
                len = $urandom_range(60, 70);
            else
                len = $urandom_range(1, 10);
            no_idle = $urandom_range(0, 3) == 0;
            for (int k = 0; k < len; k++)
                send_item(draw_value(), k == len - 1, draw_gap(no_idle), 1'b0);
        end
        start <= 1'b0;

        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
`default_nettype wire

### counting_sort_engine_top.f
src/cse_pkg.sv
src/cse_datapath.sv
src/cse_ctrl.sv
src/counting_sort_engine_top.sv
tb/testbench.sv
